// ----- design/rdad_pkg.sv -----
// shared widths, constants, wheel record type, scroll helper and digit step helpers for the altitude drum
package rdad_pkg;

    localparam int ALT_W    = 16;
    localparam int FRAC_W   = 3;
    localparam int COUNT_W  = ALT_W - FRAC_W;
    localparam int COL_W    = 2;
    localparam int DIGIT_W  = 4;
    localparam int OFFSET_W = 12;
    localparam int NUM_COLS = 4;
    localparam int PROD_W   = 27;

    localparam logic [COL_W-1:0] COL_LAST = 2'd3;

    // reciprocal constants, exact for every 13-bit count
    localparam logic [PROD_W-1:0] RECIP_10   = 27'd6554;
    localparam logic [PROD_W-1:0] RECIP_100  = 27'd5243;
    localparam logic [PROD_W-1:0] RECIP_1000 = 27'd8389;

    localparam logic [6:0]  LOW_RANGE_LIMIT = 7'd100;
    localparam logic [8:0]  LOW_SCALE       = 9'd61;
    localparam logic [8:0]  HIGH_SCALE      = 9'd6;
    localparam logic [10:0] SCROLL_BASE     = 11'd1000;
    localparam logic [3:0]  LOW_ROLL_MAX    = 4'd8;
    localparam logic [6:0]  HIGH_ROLL_MAX   = 7'd80;
    localparam logic [6:0]  HIGH_ROLL_START = 7'd24;
    localparam logic [2:0]  LOW_ROLL_START  = 3'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
    localparam logic [OFFSET_W-1:0] REST_OFFSET = 12'd2000;
    localparam logic [OFFSET_W-1:0] MAX_OFFSET  = 12'd2244;

    typedef struct packed {
        logic [DIGIT_W-1:0]  digit_prev;
        logic [DIGIT_W-1:0]  digit_mid;
        logic [DIGIT_W-1:0]  digit_next;
        logic [OFFSET_W-1:0] scroll_offset;
    } wheel_t;

    // product is shift times scale; result is (product/4 + 1000) doubled
    function automatic logic [OFFSET_W-1:0] scroll_of(input logic [8:0] product);
        logic [10:0] sum;
        sum = 11'(product[8:2]) + SCROLL_BASE;
        return {sum, 1'b0};
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_dec(input logic [DIGIT_W-1:0] d);
        return (d == 4'd0) ? DIGIT_NINE : d - 4'd1;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_inc(input logic [DIGIT_W-1:0] d);
        return (d == DIGIT_NINE) ? 4'd0 : d + 4'd1;
    endfunction

endpackage

// ----- design/rdad_alt_if.sv -----
// altitude item channel
interface rdad_alt_if;
    import rdad_pkg::*;

    logic              valid;
    logic              ready;
    logic [ALT_W-1:0]  altitude;

    modport source (output valid, output altitude, input ready);
    modport sink   (input valid, input altitude, output ready);
endinterface

// ----- design/rdad_wheel_if.sv -----
// wheel result item channel
interface rdad_wheel_if;
    import rdad_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    column;
    logic [DIGIT_W-1:0]  digit_prev;
    logic [DIGIT_W-1:0]  digit_mid;
    logic [DIGIT_W-1:0]  digit_next;
    logic [OFFSET_W-1:0] scroll_offset;
    logic                last;

    modport source (output valid, output column, output digit_prev, output digit_mid,
                    output digit_next, output scroll_offset, output last, input ready);
    modport sink   (input valid, input column, input digit_prev, input digit_mid,
                    input digit_next, input scroll_offset, input last, output ready);
endinterface

// ----- design/rolling_digit_altitude_drum.sv -----
// rolling digit altitude drum: splits an altitude into four digit wheel results
// an accepted altitude goes to the input register, then to the wheel buffer
// four wheel items per altitude, one per cycle while the wheel port is ready
// the single result port serializing the four wheels limits the altitude rate
// a new altitude is taken while the previous one's wheels are still being delivered
// reset clears the valid flags and the column counter; payload registers are not reset
module rolling_digit_altitude_drum (
    input  logic          clk,
    input  logic          rst_n,
    rdad_alt_if.sink      alt,
    rdad_wheel_if.source  wheel
);
    import rdad_pkg::*;

    logic                 in_vld_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [9:0]           q10_reg;
    logic [6:0]           q100_reg;
    logic [3:0]           q1000_reg;

    logic                 buf_vld_reg;
    logic [COL_W-1:0]     col_reg;
    wheel_t               wheel_reg [NUM_COLS];

    logic [COUNT_W-1:0]   in_count;
    logic [PROD_W-1:0]    prod10;
    logic [PROD_W-1:0]    prod100;
    logic [PROD_W-1:0]    prod1000;

    logic                 in_take;
    logic                 out_take;
    logic                 out_done;
    logic                 buf_load;

    logic [DIGIT_W-1:0]   dig [NUM_COLS];
    logic [OFFSET_W-1:0]  off [NUM_COLS];
    logic [NUM_COLS-1:0]  shown;
    wheel_t               wheel_next [NUM_COLS];

    logic [COUNT_W-1:0]   rem0;
    logic [9:0]           rem1;
    logic [6:0]           rem2;
    logic                 low_range;
    logic [3:0]           low_k;
    logic [6:0]           hi_d;
    logic [7:0]           hi_k;
    logic [6:0]           hi_k_clamped;
    logic [OFFSET_W-1:0]  roll_off;

    // handshake
    assign out_take = buf_vld_reg && wheel.ready;
    assign out_done = out_take && (col_reg == COL_LAST);
    assign buf_load = in_vld_reg && (!buf_vld_reg || out_done);
    assign alt.ready = !in_vld_reg || buf_load;
    assign in_take  = alt.valid && alt.ready;

    // quotients by reciprocal multiply
    assign in_count = alt.altitude[ALT_W-1:FRAC_W];
    assign prod10   = PROD_W'(in_count) * RECIP_10;
    assign prod100  = PROD_W'(in_count) * RECIP_100;
    assign prod1000 = PROD_W'(in_count) * RECIP_1000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            buf_vld_reg <= 1'b0;
            col_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (buf_load)
                in_vld_reg <= 1'b0;

            if (buf_load)
                buf_vld_reg <= 1'b1;
            else if (out_done)
                buf_vld_reg <= 1'b0;

            if (buf_load)
                col_reg <= '0;
            else if (out_take)
                col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            frac_reg  <= alt.altitude[FRAC_W-1:0];
            count_reg <= in_count;
            q10_reg   <= prod10[25:16];
            q100_reg  <= prod100[25:19];
            q1000_reg <= prod1000[26:23];
        end
        if (buf_load)
        begin
            for (int c = 0; c < NUM_COLS; c++)
                wheel_reg[c] <= wheel_next[c];
        end
    end

    // digits, offsets
    always_comb
    begin
        rem0   = count_reg - {q10_reg, 3'b000} - COUNT_W'({q10_reg, 1'b0});
        rem1   = q10_reg - {q100_reg, 3'b000} - 10'({q100_reg, 1'b0});
        rem2   = q100_reg - 7'({q1000_reg, 3'b000}) - 7'({q1000_reg, 1'b0});
        dig[0] = rem0[DIGIT_W-1:0];
        dig[1] = rem1[DIGIT_W-1:0];
        dig[2] = rem2[DIGIT_W-1:0];
        dig[3] = q1000_reg;

        low_range = count_reg < COUNT_W'(LOW_RANGE_LIMIT);

        low_k = {(frac_reg - LOW_ROLL_START), 1'b0};
        if (low_k > LOW_ROLL_MAX)
            low_k = LOW_ROLL_MAX;

        hi_d = 7'(frac_reg) + {dig[0], 3'b000};
        hi_k = {(hi_d - HIGH_ROLL_START), 1'b0};
        hi_k_clamped = (hi_k > 8'(HIGH_ROLL_MAX)) ? HIGH_ROLL_MAX : hi_k[6:0];

        off[0]   = REST_OFFSET;
        off[1]   = REST_OFFSET;
        off[2]   = REST_OFFSET;
        off[3]   = REST_OFFSET;
        roll_off = REST_OFFSET;

        if (low_range)
        begin
            shown = 4'b0111;
            off[0] = scroll_of(9'(frac_reg) * LOW_SCALE);
            if (frac_reg > LOW_ROLL_START && dig[0] == DIGIT_NINE)
            begin
                roll_off = scroll_of(9'(low_k) * LOW_SCALE);
                off[1] = roll_off;
                if (dig[1] == DIGIT_NINE)
                    off[2] = roll_off;
            end
        end
        else
        begin
            shown = 4'b1110;
            off[0] = scroll_of(9'(hi_d) * HIGH_SCALE);
            off[1] = off[0];
            if (hi_d > HIGH_ROLL_START && dig[1] == DIGIT_NINE)
            begin
                roll_off = scroll_of(9'(hi_k_clamped) * HIGH_SCALE);
                off[2] = roll_off;
                if (dig[2] == DIGIT_NINE)
                    off[3] = roll_off;
            end
        end

        for (int c = 0; c < NUM_COLS; c++)
        begin
            wheel_next[c].scroll_offset = off[c];
            if (shown[c])
            begin
                wheel_next[c].digit_prev = digit_dec(dig[c]);
                wheel_next[c].digit_mid  = dig[c];
                wheel_next[c].digit_next = digit_inc(dig[c]);
            end
            else
            begin
                wheel_next[c].digit_prev = '0;
                wheel_next[c].digit_mid  = '0;
                wheel_next[c].digit_next = '0;
            end
        end
    end

    // result port
    assign wheel.valid         = buf_vld_reg;
    assign wheel.column        = col_reg;
    assign wheel.digit_prev    = wheel_reg[col_reg].digit_prev;
    assign wheel.digit_mid     = wheel_reg[col_reg].digit_mid;
    assign wheel.digit_next    = wheel_reg[col_reg].digit_next;
    assign wheel.scroll_offset = wheel_reg[col_reg].scroll_offset;
    assign wheel.last          = (col_reg == COL_LAST);

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        wheel.valid |-> (wheel.scroll_offset >= REST_OFFSET) &&
                        (wheel.scroll_offset <= MAX_OFFSET))
        else $error("scroll offset out of range");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (wheel.valid && wheel.ready && !wheel.last) |=>
            (wheel.valid && (col_reg == $past(col_reg) + 2'd1)))
        else $error("column did not advance within an item");

    a_new_item_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (wheel.valid && wheel.ready && wheel.last) |=> (col_reg == '0))
        else $error("new item does not start at column zero");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (alt.valid && alt.ready) |=> in_vld_reg)
        else $error("accepted item lost");

    a_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
        wheel.valid |-> (wheel.digit_mid <= DIGIT_NINE) &&
                        (wheel.digit_prev <= DIGIT_NINE) &&
                        (wheel.digit_next <= DIGIT_NINE))
        else $error("wheel digit out of range");

endmodule

// ----- bench/rolling_digit_altitude_drum_test.sv -----
// self-checking bench for the altitude drum: directed table then random altitudes with stalls
`timescale 1ns / 100ps

module rolling_digit_altitude_drum_test;
    import rdad_pkg::*;

    typedef wheel_t [0:NUM_COLS-1] wheel_set_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        wheel_t           wheel;
        logic             last;
    } wheel_item_t;

    typedef struct packed {
        logic [ALT_W-1:0] altitude;
        logic             typed;
        wheel_set_t       wheels;
    } stim_row_t;

    localparam int RANDOM_ITEMS   = 436;
    localparam int HOLD_ITEM      = 120;
    localparam int DRAIN_ITEM     = 260;
    localparam int LONG_HOLD      = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam wheel_t ZERO_REST  = '{4'd9, 4'd0, 4'd1, 12'd2000};
    localparam wheel_t BLANK_REST = '{4'd0, 4'd0, 4'd0, 12'd2000};

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, '{ZERO_REST, ZERO_REST, ZERO_REST, BLANK_REST}},
        '{16'h0007, 1'b1, '{'{4'd9, 4'd0, 4'd1, 12'd2212}, ZERO_REST, ZERO_REST, BLANK_REST}},
        '{16'd799, 1'b1, '{'{4'd8, 4'd9, 4'd0, 12'd2212}, '{4'd8, 4'd9, 4'd0, 12'd2244},
                           '{4'd9, 4'd0, 4'd1, 12'd2244}, BLANK_REST}},
        '{16'd7999, 1'b1, '{'{4'd0, 4'd0, 4'd0, 12'd2236}, '{4'd8, 4'd9, 4'd0, 12'd2236},
                            '{4'd8, 4'd9, 4'd0, 12'd2240}, '{4'd9, 4'd0, 4'd1, 12'd2240}}},
        '{16'hFFFF, 1'b1, '{'{4'd0, 4'd0, 4'd0, 12'd2044}, '{4'd8, 4'd9, 4'd0, 12'd2044},
                            '{4'd0, 4'd1, 4'd2, 12'd2000}, '{4'd7, 4'd8, 4'd9, 12'd2000}}},
        '{16'd74, 1'b0, '0},
        '{16'd75, 1'b0, '0},
        '{16'd157, 1'b0, '0},
        '{16'd795, 1'b0, '0},
        '{16'd791, 1'b0, '0},
        '{16'd401, 1'b0, '0},
        '{16'd800, 1'b0, '0},
        '{16'd807, 1'b0, '0},
        '{16'd1544, 1'b0, '0},
        '{16'd1545, 1'b0, '0},
        '{16'd7924, 1'b0, '0},
        '{16'd8000, 1'b0, '0},
        '{16'd15999, 1'b0, '0},
        '{16'd34574, 1'b0, '0},
        '{16'd40797, 1'b0, '0},
        '{16'd63999, 1'b0, '0},
        '{16'd65520, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'h5555, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rdad_alt_if   alt_ch ();
    rdad_wheel_if wheel_ch ();

    rolling_digit_altitude_drum u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .alt   (alt_ch),
        .wheel (wheel_ch)
    );

    always #1 clk = ~clk;

    wheel_item_t pending_wheels [$];
    wheel_item_t due_wheel;
    wheel_item_t seen_wheel;
    int          mismatches = 0;
    int          items_offered = 0;
    int          wheels_taken = 0;
    int          stall_cycles = 0;
    bit          long_hold_due = 1'b0;

    function automatic logic [OFFSET_W-1:0] wheel_offset(input int unsigned shift,
                                                         input int unsigned scale);
        return OFFSET_W'(((shift * scale / 4) + 1000) * 2);
    endfunction

    function automatic wheel_set_t wheels_for_altitude(input logic [ALT_W-1:0] altitude);
        wheel_set_t          w;
        int unsigned         frac;
        int unsigned         count;
        int unsigned         joined;
        int unsigned         roll;
        int unsigned         dig [NUM_COLS];
        logic [OFFSET_W-1:0] off [NUM_COLS];
        bit                  shown [NUM_COLS];
        frac  = altitude[FRAC_W-1:0];
        count = altitude[ALT_W-1:FRAC_W];
        dig[0] = count % 10;
        dig[1] = (count / 10) % 10;
        dig[2] = (count / 100) % 10;
        dig[3] = (count / 1000) % 10;
        for (int c = 0; c < NUM_COLS; c++)
            off[c] = REST_OFFSET;
        if (count < 100)
        begin
            if (frac > 2 && dig[0] == 9)
            begin
                roll = 2 * (frac - 2);
                if (roll > 8)
                    roll = 8;
                off[1] = wheel_offset(roll, 61);
                if (dig[1] == 9)
                    off[2] = off[1];
            end
            off[0] = wheel_offset(frac, 61);
            shown = '{1'b1, 1'b1, 1'b1, 1'b0};
        end
        else
        begin
            joined = frac + 8 * dig[0];
            if (joined > 24 && dig[1] == 9)
            begin
                roll = 2 * (joined - 24);
                if (roll > 80)
                    roll = 80;
                off[2] = wheel_offset(roll, 6);
                if (dig[2] == 9)
                    off[3] = off[2];
            end
            off[0] = wheel_offset(joined, 6);
            off[1] = off[0];
            shown = '{1'b0, 1'b1, 1'b1, 1'b1};
        end
        for (int c = 0; c < NUM_COLS; c++)
        begin
            w[c].digit_prev    = shown[c] ? DIGIT_W'((dig[c] + 9) % 10) : '0;
            w[c].digit_mid     = shown[c] ? DIGIT_W'(dig[c]) : '0;
            w[c].digit_next    = shown[c] ? DIGIT_W'((dig[c] + 1) % 10) : '0;
            w[c].scroll_offset = off[c];
        end
        return w;
    endfunction

    // mostly counts full of nines so the roll paths get exercised
    function automatic logic [ALT_W-1:0] random_altitude();
        int unsigned count;
        int unsigned dig [NUM_COLS];
        case ($urandom_range(0, 3))
            0: return ALT_W'($urandom);
            1: count = $urandom_range(0, 9) * 10 + ($urandom_range(0, 1) ? 9 : $urandom_range(0, 9));
            default:
            begin
                for (int c = 0; c < NUM_COLS - 1; c++)
                    dig[c] = $urandom_range(0, 1) ? 9 : $urandom_range(0, 9);
                dig[3] = $urandom_range(0, 8);
                count = dig[3] * 1000 + dig[2] * 100 + dig[1] * 10 + dig[0];
                if (count > 8191)
                    count = count - 1000;
            end
        endcase
        return {COUNT_W'(count), FRAC_W'($urandom_range(0, 7))};
    endfunction

    function automatic int pause_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic string wheel_text(input wheel_item_t r);
        return $sformatf("col %0d prev %0d mid %0d next %0d offset %0d last %0d", r.column,
                         r.wheel.digit_prev, r.wheel.digit_mid, r.wheel.digit_next,
                         r.wheel.scroll_offset, r.last);
    endfunction

    task automatic offer_altitude(input logic [ALT_W-1:0] altitude, input wheel_set_t wheels);
        int  gap;
        bit  quiet;
        quiet = ((items_offered / 50) % 3 == 1) ||
                (items_offered >= HOLD_ITEM && items_offered < HOLD_ITEM + 30);
        gap = pause_cycles(quiet);
        if (gap > 0)
        begin
            alt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        alt_ch.valid    <= 1'b1;
        alt_ch.altitude <= altitude;
        do @(posedge clk); while (!alt_ch.ready);
        for (int c = 0; c < NUM_COLS; c++)
            pending_wheels.push_back('{COL_W'(c), wheels[c], c == NUM_COLS - 1});
        items_offered++;
    endtask

    initial
    begin
        logic [ALT_W-1:0] altitude;
        rst_n           <= 1'b0;
        alt_ch.valid    <= 1'b0;
        alt_ch.altitude <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_altitude(DIRECTED[i].altitude, DIRECTED[i].typed ? DIRECTED[i].wheels
                                                 : wheels_for_altitude(DIRECTED[i].altitude));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (items_offered == HOLD_ITEM)
                long_hold_due = 1'b1;
            if (items_offered == DRAIN_ITEM)
            begin
                alt_ch.valid <= 1'b0;
                do @(posedge clk); while (pending_wheels.size() != 0);
            end
            altitude = random_altitude();
            offer_altitude(altitude, wheels_for_altitude(altitude));
        end
        alt_ch.valid <= 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("rolling_digit_altitude_drum_test: done, clean");
        else
            $display("rolling_digit_altitude_drum_test: done, errors");
        $finish;
    end

    initial
    begin
        int gap;
        wheel_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                wheel_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = pause_cycles((wheels_taken / 150) % 3 == 2);
            if (gap > 0)
            begin
                wheel_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            wheel_ch.ready <= 1'b1;
            do @(posedge clk); while (!wheel_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (wheel_ch.valid && wheel_ch.ready)
        begin
            wheels_taken++;
            seen_wheel = '{wheel_ch.column,
                           '{wheel_ch.digit_prev, wheel_ch.digit_mid, wheel_ch.digit_next,
                             wheel_ch.scroll_offset},
                           wheel_ch.last};
            if (pending_wheels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected wheel item: %s", wheel_text(seen_wheel));
            end
            else
            begin
                due_wheel = pending_wheels.pop_front();
                if (seen_wheel.column !== due_wheel.column
                    || seen_wheel.wheel.digit_prev !== due_wheel.wheel.digit_prev
                    || seen_wheel.wheel.digit_mid !== due_wheel.wheel.digit_mid
                    || seen_wheel.wheel.digit_next !== due_wheel.wheel.digit_next
                    || seen_wheel.wheel.scroll_offset !== due_wheel.wheel.scroll_offset
                    || seen_wheel.last !== due_wheel.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("wheel mismatch: expected %s, got %s", wheel_text(due_wheel),
                                 wheel_text(seen_wheel));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((alt_ch.valid && alt_ch.ready) || (wheel_ch.valid && wheel_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rolling_digit_altitude_drum_test: done, errors");
            $finish;
        end
    end

endmodule
